### hw/rtl/melody_tone_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Melody tone sequencer assertion macros
// Shared property forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef MELODY_TONE_SEQUENCER_ASSERT_SVH
`define MELODY_TONE_SEQUENCER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("melody tone sequencer: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("melody tone sequencer: next-cycle check failed");

`endif

### hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// Melody tone sequencer package
// Table size, field widths, codes and beat types of the sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Note table geometry
    localparam int NOTE_SLOTS = 64;
    localparam int PTR_W      = $clog2(NOTE_SLOTS);
    localparam int CNT_W      = PTR_W + 1;

    // Timing widths
    localparam int ELAPSED_W  = 26;
    localparam int PERIOD_W   = 16;
    localparam int DIV_STEPS  = ELAPSED_W;
    localparam int DIVC_W     = $clog2(DIV_STEPS);

    // Tone constants
    localparam logic [ELAPSED_W-1:0] US_PER_S   = ELAPSED_W'(1000000);
    localparam logic [9:0]           US_PER_MS  = 10'd1000;
    localparam logic [15:0]          FREQ_MIN   = 16'd20;
    localparam logic [PERIOD_W-1:0]  PERIOD_MIN = PERIOD_W'(2);

    // Item modes
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_PLAY = 2'd2,
        MODE_STOP = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOOP_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_MELODY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_CLOCKS_PER_US = 2'd2;

    typedef struct packed {
        mode_t       mode;
        logic [5:0]  note_slot;
        logic [15:0] note_freq_hz;
        logic [15:0] note_dur_ms;
    } item_t;

    typedef struct packed {
        logic       beep;
        logic       playing;
        logic [5:0] current_note;
    } result_t;

endpackage

### hw/rtl/melody_tone_sequencer.sv
// ----------------------------------------------------------------------------
// Melody tone sequencer
// Square-wave melody player: note table in a synchronous memory, per-note
// period and phase set up by a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   item    : one beat per command: tick (one prescaler step), load a note entry,
//             play from note 0, or stop. Every beat returns one result beat.
//   result  : buzzer level, playing flag and index of the sounding note.
//   cfg     : register writes (loop enable, melody length, clocks per us),
//             taken at any time, meant only while the block is idle.
// Sequencing:
//   Tick, stop and load beats that need no table read give a registered
//   result, and the next beat is taken in the following cycle unless the
//   output is stalled. Play, a note change and a load into the sounding slot
//   run one memory read of the entry, then two 26-step passes of the shared
//   restoring divider (period = 1000000/max(freq, 20), then phase of the
//   elapsed time in that period); no new beat is taken until its result is out.
// Reset: playback stops, pointer and counters clear, the beep is low and the
//   note table holds no defined data until loaded.
// Stall: a result waiting on result_ready holds; one more beat is still
//   accepted and processed, and its result is held until the slot frees.
// ----------------------------------------------------------------------------
`include "melody_tone_sequencer_assert.svh"

module melody_tone_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  mts_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_ready,
    output mts_pkg::result_t result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);
    import mts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_RDW,
        ST_DIV1,
        ST_DIV2,
        ST_EMIT
    } state_t;

    // Note table: duration in bits 31..16, frequency in bits 15..0
    logic [31:0]            note_mem [NOTE_SLOTS];
    logic [31:0]            mem_q_reg;
    logic                   mem_wr;
    logic                   mem_rd;
    logic [PTR_W-1:0]       mem_wr_addr;

    state_t                 state_reg, state_next;
    logic                   playing_reg, playing_next;
    logic                   beep_reg, beep_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [7:0]             prescale_reg, prescale_next;
    logic                   set_beep_reg, set_beep_next;

    // Cached view of the sounding note
    logic                   freq_nz_reg, freq_nz_next;
    logic [ELAPSED_W-1:0]   dur_us_reg, dur_us_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [PERIOD_W-1:0]    phase_reg, phase_next;

    // Divider
    logic [ELAPSED_W-1:0]   div_dvd_reg, div_dvd_next;
    logic [ELAPSED_W-1:0]   div_q_reg, div_q_next;
    logic [PERIOD_W-1:0]    div_rem_reg, div_rem_next;
    logic [PERIOD_W-1:0]    div_dsr_reg, div_dsr_next;
    logic [DIVC_W-1:0]      div_cnt_reg, div_cnt_next;
    logic [PERIOD_W:0]      div_sh;
    logic                   div_ge;
    logic [PERIOD_W:0]      div_rem_step;
    logic [ELAPSED_W-1:0]   div_q_step;
    logic                   div_last;

    // Configuration
    logic                   loop_en_reg, loop_en_next;
    logic [6:0]             mlen_reg, mlen_next;
    logic [7:0]             cpu_reg, cpu_next;

    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;

    // Tick arithmetic
    logic [7:0]             cpu_eff;
    logic [8:0]             ps_inc;
    logic                   us_step;
    logic [ELAPSED_W-1:0]   el_tick;
    logic [PERIOD_W-1:0]    ph_inc;
    logic [PERIOD_W-1:0]    ph_tick;
    logic [31:0]            len_full;
    logic [CNT_W-1:0]       len_eff;
    logic [CNT_W-1:0]       ptr_inc;
    logic [15:0]            rd_freq;
    logic [15:0]            rd_dur;
    logic [25:0]            dur_prod;
    logic                   slot_ok;
    logic                   refresh;
    logic                   out_free;
    logic                   accept;

    assign item_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign accept       = item_valid && item_ready;
    assign out_free     = !result_valid_reg || result_ready;

    // Tick arithmetic on the cached note
    always_comb
    begin
        cpu_eff = (cpu_reg == 8'd0) ? 8'd1 : cpu_reg;
        ps_inc  = {1'b0, prescale_reg} + 9'd1;
        us_step = (ps_inc >= {1'b0, cpu_eff});
        el_tick = us_step ? (elapsed_reg + ELAPSED_W'(1)) : elapsed_reg;
        ph_inc  = phase_reg + PERIOD_W'(1);
        if (!us_step)
            ph_tick = phase_reg;
        else if (ph_inc == period_reg)
            ph_tick = '0;
        else
            ph_tick = ph_inc;

        len_full = 32'(mlen_reg);
        if (len_full == 32'd0)
            len_full = 32'd1;
        if (len_full > NOTE_SLOTS)
            len_full = 32'(NOTE_SLOTS);
        len_eff = CNT_W'(len_full);
        ptr_inc = {1'b0, ptr_reg} + CNT_W'(1);

        rd_freq  = mem_q_reg[15:0];
        rd_dur   = mem_q_reg[31:16];
        dur_prod = 26'(rd_dur) * 26'(US_PER_MS);
        slot_ok  = (32'(item.note_slot) < NOTE_SLOTS);
    end

    // One restoring division step
    always_comb
    begin
        div_sh       = {div_rem_reg, div_dvd_reg[ELAPSED_W-1]};
        div_ge       = (div_sh >= {1'b0, div_dsr_reg});
        div_rem_step = div_ge ? (div_sh - {1'b0, div_dsr_reg}) : div_sh;
        div_q_step   = {div_q_reg[ELAPSED_W-2:0], div_ge};
        div_last     = (div_cnt_reg == DIVC_W'(DIV_STEPS - 1));
    end

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        playing_next      = playing_reg;
        beep_next         = beep_reg;
        ptr_next          = ptr_reg;
        elapsed_next      = elapsed_reg;
        prescale_next     = prescale_reg;
        set_beep_next     = set_beep_reg;
        freq_nz_next      = freq_nz_reg;
        dur_us_next       = dur_us_reg;
        period_next       = period_reg;
        phase_next        = phase_reg;
        div_dvd_next      = div_dvd_reg;
        div_q_next        = div_q_reg;
        div_rem_next      = div_rem_reg;
        div_dsr_next      = div_dsr_reg;
        div_cnt_next      = div_cnt_reg;
        loop_en_next      = loop_en_reg;
        mlen_next         = mlen_reg;
        cpu_next          = cpu_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        mem_wr            = 1'b0;
        mem_rd            = 1'b0;
        mem_wr_addr       = PTR_W'(item.note_slot);
        refresh           = 1'b0;

        // Register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOOP_ENABLE:   loop_en_next = cfg_data[0];
                CFG_MELODY_LENGTH: mlen_next    = cfg_data[6:0];
                CFG_CLOCKS_PER_US: cpu_next     = cfg_data;
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.mode)
                        MODE_TICK:
                        begin
                            if (playing_reg)
                            begin
                                prescale_next = us_step ? 8'd0 : ps_inc[7:0];
                                elapsed_next  = el_tick;
                                phase_next    = ph_tick;
                                if (el_tick >= dur_us_reg)
                                begin
                                    // Note time is up: wrap, stop or advance
                                    if (ptr_inc >= len_eff && !loop_en_reg)
                                    begin
                                        playing_next = 1'b0;
                                        beep_next    = 1'b0;
                                    end
                                    else
                                    begin
                                        ptr_next      = (ptr_inc >= len_eff) ? '0
                                                        : ptr_inc[PTR_W-1:0];
                                        elapsed_next  = '0;
                                        prescale_next = 8'd0;
                                        set_beep_next = 1'b1;
                                        refresh       = 1'b1;
                                    end
                                end
                                else
                                begin
                                    beep_next = freq_nz_reg && (ph_tick < (period_reg >> 1));
                                end
                            end
                        end
                        MODE_LOAD:
                        begin
                            if (slot_ok)
                            begin
                                mem_wr = 1'b1;
                                // Reload the cache if the sounding entry changed
                                if (PTR_W'(item.note_slot) == ptr_reg)
                                begin
                                    set_beep_next = 1'b0;
                                    refresh       = 1'b1;
                                end
                            end
                        end
                        MODE_PLAY:
                        begin
                            playing_next  = 1'b1;
                            ptr_next      = '0;
                            elapsed_next  = '0;
                            prescale_next = 8'd0;
                            set_beep_next = 1'b1;
                            refresh       = 1'b1;
                        end
                        MODE_STOP:
                        begin
                            playing_next = 1'b0;
                            beep_next    = 1'b0;
                        end
                        default: ;
                    endcase

                    if (refresh)
                        state_next = ST_RD;
                    else if (!out_free)
                        state_next = ST_EMIT;
                    else
                    begin
                        result_valid_next         = 1'b1;
                        result_next.beep          = beep_next;
                        result_next.playing       = playing_next;
                        result_next.current_note  = 6'(ptr_next);
                    end
                end
            end
            ST_RD:
            begin
                // Fetch the sounding entry
                mem_rd     = 1'b1;
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                freq_nz_next = (rd_freq != 16'd0);
                dur_us_next  = dur_prod;
                if (set_beep_reg)
                    beep_next = (rd_freq != 16'd0);
                div_dvd_next = US_PER_S;
                div_q_next   = '0;
                div_rem_next = '0;
                div_dsr_next = (rd_freq < FREQ_MIN) ? FREQ_MIN : rd_freq;
                div_cnt_next = '0;
                state_next   = ST_DIV1;
            end
            ST_DIV1:
            begin
                div_dvd_next = div_dvd_reg << 1;
                div_q_next   = div_q_step;
                div_rem_next = div_rem_step[PERIOD_W-1:0];
                div_cnt_next = div_cnt_reg + DIVC_W'(1);
                if (div_last)
                begin
                    // Period done: start the phase pass on elapsed time
                    period_next  = (div_q_step < ELAPSED_W'(PERIOD_MIN)) ? PERIOD_MIN
                                   : div_q_step[PERIOD_W-1:0];
                    div_dvd_next = elapsed_reg;
                    div_q_next   = '0;
                    div_rem_next = '0;
                    div_dsr_next = (div_q_step < ELAPSED_W'(PERIOD_MIN)) ? PERIOD_MIN
                                   : div_q_step[PERIOD_W-1:0];
                    div_cnt_next = '0;
                    state_next   = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                div_dvd_next = div_dvd_reg << 1;
                div_q_next   = div_q_step;
                div_rem_next = div_rem_step[PERIOD_W-1:0];
                div_cnt_next = div_cnt_reg + DIVC_W'(1);
                if (div_last)
                begin
                    phase_next = div_rem_step[PERIOD_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Hold the state snapshot until the output slot frees
                if (out_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.beep         = beep_reg;
                    result_next.playing      = playing_reg;
                    result_next.current_note = 6'(ptr_reg);
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            playing_reg      <= 1'b0;
            beep_reg         <= 1'b0;
            ptr_reg          <= '0;
            elapsed_reg      <= '0;
            prescale_reg     <= 8'd0;
            set_beep_reg     <= 1'b0;
            loop_en_reg      <= 1'b0;
            mlen_reg         <= 7'd1;
            cpu_reg          <= 8'd72;
            result_valid_reg <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            playing_reg      <= playing_next;
            beep_reg         <= beep_next;
            ptr_reg          <= ptr_next;
            elapsed_reg      <= elapsed_next;
            prescale_reg     <= prescale_next;
            set_beep_reg     <= set_beep_next;
            loop_en_reg      <= loop_en_next;
            mlen_reg         <= mlen_next;
            cpu_reg          <= cpu_next;
            result_valid_reg <= result_valid_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    // Payload and cache registers
    always_ff @(posedge clk)
    begin
        freq_nz_reg <= freq_nz_next;
        dur_us_reg  <= dur_us_next;
        period_reg  <= period_next;
        phase_reg   <= phase_next;
        div_dvd_reg <= div_dvd_next;
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        div_dsr_reg <= div_dsr_next;
        result_reg  <= result_next;
    end

    // Note table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            note_mem[mem_wr_addr] <= {item.note_dur_ms, item.note_freq_hz};
        if (mem_rd)
            mem_q_reg <= note_mem[ptr_reg];
    end

    // Checks
    `MTS_ASSERT_IMP(a_phase_in_period, clk, rst_n, (state_reg == ST_IDLE) && playing_reg, phase_reg < period_reg)
    `MTS_ASSERT_IMP(a_silent_when_stopped, clk, rst_n, !playing_reg, !beep_reg)
    `MTS_ASSERT_NEXT(a_play_reads_table, clk, rst_n, accept && (item.mode == MODE_PLAY), state_reg == ST_RD)

endmodule
